### design/cv2d_pkg.sv
// Shared types and constants for the same-padding 2-D convolution block.
// Used by the channel interfaces, the MAC datapath and the top level.
package cv2d_pkg;

    // Payload widths fixed by the item format
    localparam int OP_W    = 2;
    localparam int KSEL_W  = 3;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 38;
    localparam int KIDX_W  = 3;

    // Configuration register widths
    localparam int KSIZE_W  = 3;
    localparam int KCOUNT_W = 4;
    localparam int DIM_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Signed window coordinate: row + tap - pad spans -3..66
    localparam int COORD_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_WR_WEIGHT = 2'd0,
        OP_WR_PIXEL  = 2'd1,
        OP_QUERY     = 2'd2,
        OP_NONE      = 2'd3
    } cv2d_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KSIZE  = 3'd0,
        CFG_KCOUNT = 3'd1,
        CFG_ROWS   = 3'd2,
        CFG_COLS   = 3'd3
    } cv2d_cfg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } cv2d_state_t;

    // Control that travels with each tap through the MAC pipeline
    typedef struct packed {
        logic              valid;
        logic              in_win;   // pixel lies inside the image
        logic              first;    // first tap of a kernel
        logic              last_k;   // last tap of a kernel
        logic [KIDX_W-1:0] kidx;
        logic              is_last;  // tap belongs to the last active kernel
    } cv2d_tag_t;

endpackage

### design/cv2d_cmd_if.sv
// Command channel: weight writes, pixel writes and output queries.
// Depends on cv2d_pkg for field widths.
interface cv2d_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [cv2d_pkg::OP_W-1:0]           op;
    logic [cv2d_pkg::KSEL_W-1:0]         kernel_sel;
    logic [cv2d_pkg::POS_W-1:0]          row;
    logic [cv2d_pkg::POS_W-1:0]          col;
    logic signed [cv2d_pkg::VAL_W-1:0]   value;

    modport source (output valid, op, kernel_sel, row, col, value, input ready);
    modport sink   (input valid, op, kernel_sel, row, col, value, output ready);
endinterface

### design/cv2d_res_if.sv
// Result channel: one window sum per active kernel.
// Depends on cv2d_pkg for field widths.
interface cv2d_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [cv2d_pkg::SUM_W-1:0]   sum;
    logic [cv2d_pkg::KIDX_W-1:0]         kernel_index;
    logic                                is_last;

    modport source (output valid, sum, kernel_index, is_last, input ready);
    modport sink   (input valid, sum, kernel_index, is_last, output ready);
endinterface

### design/cv2d_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on cv2d_pkg for field widths.
interface cv2d_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [cv2d_pkg::CFG_IDX_W-1:0]      index;
    logic [cv2d_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/cv2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cv2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/cv2d_mac.sv
// Shared multiply-accumulate: product stage, accumulator and result register.
// Depends on cv2d_pkg (tag struct, widths) and cv2d_res_if.
module cv2d_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cv2d_pkg::cv2d_tag_t                  tag,
    input  logic signed [cv2d_pkg::VAL_W-1:0]    pixel,
    input  logic signed [cv2d_pkg::VAL_W-1:0]    weight,
    output logic                                 adv,
    cv2d_res_if.source                           res
);
    import cv2d_pkg::*;

    cv2d_tag_t                tag2_reg;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_sum;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic [KIDX_W-1:0]        out_kidx_reg;
    logic                     out_last_reg;
    logic                     load_out;

    // The whole pipeline holds while a result sits untaken
    assign adv = !out_valid_reg || res.ready;

    // signed 16x16 product at full width
    assign prod_full = pixel * weight;

    assign acc_sum  = (tag2_reg.first ? '0 : acc_reg)
                    + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign load_out = adv && tag2_reg.valid && tag2_reg.last_k;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                tag2_reg <= tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // taps outside the image count as zero
            prod_reg <= tag.in_win ? prod_full : '0;
            if (tag2_reg.valid)
            begin
                acc_reg <= acc_sum;
            end
        end
        if (load_out)
        begin
            out_sum_reg  <= acc_sum;
            out_kidx_reg <= tag2_reg.kidx;
            out_last_reg <= tag2_reg.is_last;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.sum          = out_sum_reg;
    assign res.kernel_index = out_kidx_reg;
    assign res.is_last      = out_last_reg;

endmodule

### design/conv2d_same_multi_kernel.sv
// Same-size 2-D convolution of one stored image with up to MAX_KERNELS square kernels.
// A query walks kernel_count * kernel_size^2 window taps through one shared 16x16
// multiplier, one tap per cycle while the result side does not stall, and the command
// channel stays busy until the last tap has been issued. Each kernel's sum reaches the
// result register once its last tap has passed the RAM read and product registers and
// the accumulate; the result register lets the next command in while sums drain.
// Stores start undefined: nothing is cleared after reset. Depends on cv2d_pkg,
// cv2d_cmd_if, cv2d_res_if, cv2d_cfg_if, cv2d_ram and cv2d_mac.
module conv2d_same_multi_kernel #(
    parameter int MAX_KSIZE   = 7,
    parameter int MAX_KERNELS = 8,
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    cv2d_cmd_if.sink     cmd,
    cv2d_res_if.source   res,
    cv2d_cfg_if.sink     cfg
);
    import cv2d_pkg::*;

    localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int WT_DEPTH  = MAX_KERNELS * MAX_KSIZE * MAX_KSIZE;
    localparam int WT_AW     = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;

    // Configuration registers
    logic [KSIZE_W-1:0]  ksize_reg;
    logic [KCOUNT_W-1:0] kcount_reg;
    logic [DIM_W-1:0]    rows_reg;
    logic [DIM_W-1:0]    cols_reg;

    // Clamped configuration
    logic [KSIZE_W-1:0]  ks;
    logic [KSIZE_W-1:0]  pad;
    logic [KCOUNT_W-1:0] kc;
    logic [DIM_W-1:0]    nr;
    logic [DIM_W-1:0]    nc;

    // Sequencer
    cv2d_state_t         state_reg;
    cv2d_state_t         state_next;
    logic [KCOUNT_W-1:0] k_reg;
    logic [KCOUNT_W-1:0] k_next;
    logic [KSIZE_W-1:0]  a_reg;
    logic [KSIZE_W-1:0]  a_next;
    logic [KSIZE_W-1:0]  b_reg;
    logic [KSIZE_W-1:0]  b_next;
    logic [POS_W-1:0]    qrow_reg;
    logic [POS_W-1:0]    qcol_reg;

    logic                cmd_xfer;
    logic                cfg_xfer;
    logic                adv;
    logic                step;
    logic                b_wrap;
    logic                a_wrap;
    logic                k_done;
    logic signed [COORD_W-1:0] win_y;
    logic signed [COORD_W-1:0] win_x;

    cv2d_tag_t           tag0;
    cv2d_tag_t           tag1_reg;

    logic                img_we;
    logic [IMG_AW-1:0]   img_waddr;
    logic [IMG_AW-1:0]   img_raddr;
    logic                wt_we;
    logic [WT_AW-1:0]    wt_waddr;
    logic [WT_AW-1:0]    wt_raddr;
    logic                rd_en;
    logic [VAL_W-1:0]    img_rdata;
    logic [VAL_W-1:0]    wt_rdata;

    assign cmd_xfer = cmd.valid && cmd.ready;
    assign cfg_xfer = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    // Zero means one; values above the store limits saturate
    always_comb
    begin
        ks = (ksize_reg == '0) ? KSIZE_W'(1)
           : ((32'(ksize_reg) > MAX_KSIZE) ? KSIZE_W'(MAX_KSIZE) : ksize_reg);
        kc = (kcount_reg == '0) ? KCOUNT_W'(1)
           : ((32'(kcount_reg) > MAX_KERNELS) ? KCOUNT_W'(MAX_KERNELS) : kcount_reg);
        nr = (rows_reg == '0) ? DIM_W'(1)
           : ((32'(rows_reg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_reg);
        nc = (cols_reg == '0) ? DIM_W'(1)
           : ((32'(cols_reg) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_reg);
        pad = ks >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksize_reg  <= KSIZE_W'(3);
            kcount_reg <= KCOUNT_W'(1);
            rows_reg   <= DIM_W'(64);
            cols_reg   <= DIM_W'(64);
        end
        else if (cfg_xfer)
        begin
            case (cfg.index)
                CFG_KSIZE:  ksize_reg  <= cfg.data[KSIZE_W-1:0];
                CFG_KCOUNT: kcount_reg <= cfg.data[KCOUNT_W-1:0];
                CFG_ROWS:   rows_reg   <= cfg.data[DIM_W-1:0];
                CFG_COLS:   cols_reg   <= cfg.data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // Store writes straight from the command channel
    always_comb
    begin
        img_we = cmd_xfer && (cmd.op == OP_WR_PIXEL)
              && ({1'b0, cmd.row} < nr) && ({1'b0, cmd.col} < nc);
        img_waddr = IMG_AW'(32'(cmd.row) * MAX_COLS + 32'(cmd.col));
        wt_we = cmd_xfer && (cmd.op == OP_WR_WEIGHT)
             && (32'(cmd.kernel_sel) < MAX_KERNELS)
             && (32'(cmd.row) < MAX_KSIZE) && (32'(cmd.col) < MAX_KSIZE);
        wt_waddr = WT_AW'((32'(cmd.kernel_sel) * MAX_KSIZE + 32'(cmd.row)) * MAX_KSIZE
                          + 32'(cmd.col));
    end

    // Tap walk: b fastest, then a, then kernel
    assign step   = (state_reg == ST_RUN) && adv;
    assign b_wrap = (b_reg == ks - KSIZE_W'(1));
    assign a_wrap = (a_reg == ks - KSIZE_W'(1));
    assign k_done = (k_reg == kc - KCOUNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer && (cmd.op == OP_QUERY))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step && b_wrap && a_wrap && k_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        k_next = k_reg;
        a_next = a_reg;
        b_next = b_reg;
        if (state_reg == ST_IDLE)
        begin
            k_next = '0;
            a_next = '0;
            b_next = '0;
        end
        else if (step)
        begin
            if (b_wrap)
            begin
                b_next = '0;
                if (a_wrap)
                begin
                    a_next = '0;
                    k_next = k_reg + KCOUNT_W'(1);
                end
                else
                begin
                    a_next = a_reg + KSIZE_W'(1);
                end
            end
            else
            begin
                b_next = b_reg + KSIZE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer && (cmd.op == OP_QUERY))
        begin
            qrow_reg <= cmd.row;
            qcol_reg <= cmd.col;
        end
    end

    // Outputs of the sequencer: tap address and tag
    always_comb
    begin
        cmd.ready = (state_reg == ST_IDLE);
        rd_en     = step;
        win_y = $signed({2'b00, qrow_reg}) + $signed({{(COORD_W-KSIZE_W){1'b0}}, a_reg})
              - $signed({{(COORD_W-KSIZE_W){1'b0}}, pad});
        win_x = $signed({2'b00, qcol_reg}) + $signed({{(COORD_W-KSIZE_W){1'b0}}, b_reg})
              - $signed({{(COORD_W-KSIZE_W){1'b0}}, pad});
        img_raddr = IMG_AW'(32'(win_y[DIM_W-1:0]) * MAX_COLS + 32'(win_x[DIM_W-1:0]));
        wt_raddr  = WT_AW'((32'(k_reg) * MAX_KSIZE + 32'(a_reg)) * MAX_KSIZE + 32'(b_reg));
        tag0.valid   = (state_reg == ST_RUN);
        tag0.in_win  = !win_y[COORD_W-1] && (win_y[DIM_W-1:0] < nr)
                    && !win_x[COORD_W-1] && (win_x[DIM_W-1:0] < nc);
        tag0.first   = (a_reg == '0) && (b_reg == '0);
        tag0.last_k  = a_wrap && b_wrap;
        tag0.kidx    = k_reg[KIDX_W-1:0];
        tag0.is_last = k_done;
    end

    // Tag lines up with the registered RAM read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg <= tag0;
        end
    end

    cv2d_ram #(
        .WIDTH (VAL_W),
        .DEPTH (IMG_DEPTH)
    ) u_img_ram (
        .clk   (clk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (cmd.value),
        .re    (rd_en),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    cv2d_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WT_DEPTH)
    ) u_wt_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (cmd.value),
        .re    (rd_en),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    cv2d_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag    (tag1_reg),
        .pixel  ($signed(img_rdata)),
        .weight ($signed(wt_rdata)),
        .adv    (adv),
        .res    (res)
    );

`ifndef SYNTHESIS
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready && (cmd.op == OP_QUERY) |=> state_reg == ST_RUN)
        else $error("query transfer did not start the tap walk");

    a_last_marks_final_kernel: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.is_last == ({1'b0, res.kernel_index} == kc - KCOUNT_W'(1))))
        else $error("is_last does not match the final active kernel");

    a_tag_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tag1_reg.valid) |-> $past(state_reg == ST_RUN))
        else $error("tap entered the MAC pipeline outside a query");
`endif

endmodule
